>>> rtl/cpps_pkg.sv
`timescale 1ns / 1ps
// cpps_pkg: shared types, constants and helper functions for the coil
// polarity pulse sequencer. No dependencies.

package cpps_pkg;

    // number of coils actually wired, 2 to 4
    localparam int NUM_COILS = 4;

    localparam int CFG_W      = 18;
    localparam int CFG_ADDR_W = 3;
    localparam int COUNT_W    = 18;

    localparam logic [COUNT_W-1:0] SP_MAX = '1;

    // relay bits of coils that do not exist always read inactive
    localparam logic [3:0] COIL_MASK = 4'((1 << NUM_COILS) - 1);
    localparam logic [1:0] LAST_STEP = 2'(NUM_COILS - 1);

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_SETUP_WAIT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSE      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REST       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_COIL_ORDER = 3'd4;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_L_SET1  = 4'd1,
        PH_L_PULSE = 4'd2,
        PH_L_SET2  = 4'd3,
        PH_L_REST  = 4'd4,
        PH_H_SET1  = 4'd5,
        PH_H_PULSE = 4'd6,
        PH_H_SET2  = 4'd7,
        PH_H_REST  = 4'd8
    } t_phase;

    typedef struct packed {
        logic [17:0] setup_wait_us;
        logic [15:0] pulse_us;
        logic [17:0] rest_us;
        logic [17:0] debounce_us;
        logic [7:0]  coil_order;
    } t_cfg;

    typedef struct packed {
        logic [3:0] high_relay_n;
        logic [3:0] low_relay_n;
        logic       pulse_on;
        logic       busy_res;
        logic [1:0] step;
    } t_result;

    function automatic logic [COUNT_W-1:0] f_phase_len(t_phase ph, t_cfg cfg);
        logic [COUNT_W-1:0] len;
        case (ph)
            PH_L_SET1, PH_L_SET2, PH_H_SET1, PH_H_SET2: len = cfg.setup_wait_us;
            PH_L_PULSE, PH_H_PULSE:                     len = {2'b00, cfg.pulse_us};
            PH_L_REST, PH_H_REST:                       len = cfg.rest_us;
            default:                                    len = '0;
        endcase
        return len;
    endfunction

    // first phase at or after start whose length is nonzero, idle if none
    function automatic t_phase f_next_active(logic [3:0] start, t_cfg cfg);
        t_phase res;
        logic   found;
        res   = PH_IDLE;
        found = 1'b0;
        for (int p = 1; p <= 8; p++) begin
            if (!found && start <= 4'(p) &&
                f_phase_len(t_phase'(4'(p)), cfg) != '0) begin
                res   = t_phase'(4'(p));
                found = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/coil_polarity_pulse_sequencer_top.sv
`timescale 1ns / 1ps
// coil_polarity_pulse_sequencer_top: one tick in, one drive result out.
// The result of a tick is registered in the output register or skid entry.
// Throughput: one tick per cycle; the state update is a single registered pass.
// Input stalls only when both the output register and its skid entry are full.
// Reset (synchronous, active low) restores register defaults, idle phase,
// cleared latch and saturated time-since-press; no clearing pass is needed.
// Depends on cpps_pkg, cpps_cfg_regs, cpps_core, cpps_out_skid.

module coil_polarity_pulse_sequencer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cpps_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [cpps_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_button,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [3:0]                      o_high_relay_n,
    output logic [3:0]                      o_low_relay_n,
    output logic                            o_pulse_on,
    output logic                            o_busy_res,
    output logic [1:0]                      o_step
);
    import cpps_pkg::*;

    t_cfg    cfg;
    t_result core_result;
    t_result out_result;
    logic    skid_full;
    logic    accept;

    // a tick transaction is taken whenever the skid entry is free
    assign accept     = i_in_valid && !skid_full;
    assign o_in_stall = skid_full;

    cpps_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    cpps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_button (i_button),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    cpps_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_result    (core_result),
        .i_out_stall (i_out_stall),
        .o_full      (skid_full),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_high_relay_n = out_result.high_relay_n;
    assign o_low_relay_n  = out_result.low_relay_n;
    assign o_pulse_on     = out_result.pulse_on;
    assign o_busy_res     = out_result.busy_res;
    assign o_step         = out_result.step;

endmodule

>>> rtl/cpps_cfg_regs.sv
`timescale 1ns / 1ps
// cpps_cfg_regs: configuration register file with reset defaults.
// Depends on cpps_pkg.

module cpps_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cpps_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [cpps_pkg::CFG_W-1:0]      i_cfg_data,
    output cpps_pkg::t_cfg                  o_cfg
);
    import cpps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setup_wait_us <= 18'd49900;
            r_cfg.pulse_us      <= 16'd200;
            r_cfg.rest_us       <= 18'd150000;
            r_cfg.debounce_us   <= 18'd200000;
            r_cfg.coil_order    <= 8'd177;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SETUP_WAIT: r_cfg.setup_wait_us <= i_cfg_data;
                CFG_PULSE:      r_cfg.pulse_us      <= i_cfg_data[15:0];
                CFG_REST:       r_cfg.rest_us       <= i_cfg_data;
                CFG_DEBOUNCE:   r_cfg.debounce_us   <= i_cfg_data;
                CFG_COIL_ORDER: r_cfg.coil_order    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/cpps_core.sv
`timescale 1ns / 1ps
// cpps_core: sequencer state (phase, phase counter, order index, press latch,
// time since press) and the per-tick result. Depends on cpps_pkg.

module cpps_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_button,
    input  cpps_pkg::t_cfg    i_cfg,
    output cpps_pkg::t_result o_result
);
    import cpps_pkg::*;

    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [1:0]         r_step, n_step;
    logic               r_latched, n_latched;
    logic [COUNT_W-1:0] r_since, n_since;

    logic [COUNT_W-1:0] since_inc;
    logic [COUNT_W-1:0] count_inc;
    logic               press;
    t_phase             seq_next;
    logic [1:0]         step_inc;
    logic [1:0]         coil;
    logic [3:0]         coil_bit;

    // next state
    always_comb begin
        since_inc = (r_since == SP_MAX) ? SP_MAX : r_since + 1'b1;
        count_inc = r_count + 1'b1;
        step_inc  = (r_step == LAST_STEP) ? 2'd0 : r_step + 2'd1;
        press     = i_button && !r_latched &&
                    (since_inc > i_cfg.debounce_us || since_inc == SP_MAX);
        seq_next  = PH_IDLE;

        n_phase   = r_phase;
        n_count   = r_count;
        n_step    = r_step;
        n_latched = r_latched;
        n_since   = since_inc;

        if (r_phase == PH_IDLE) begin
            if (i_button) begin
                if (press) begin
                    // zero-length phases are skipped on the press tick
                    seq_next  = f_next_active(4'(PH_L_SET1), i_cfg);
                    n_latched = 1'b1;
                    n_since   = '0;
                    n_phase   = seq_next;
                    n_count   = '0;
                    if (seq_next == PH_IDLE) begin
                        n_step = step_inc;
                    end
                end
            end else begin
                n_latched = 1'b0;
            end
        end else begin
            if (count_inc >= f_phase_len(r_phase, i_cfg)) begin
                seq_next = f_next_active(4'(r_phase) + 4'd1, i_cfg);
                n_phase  = seq_next;
                n_count  = '0;
                if (seq_next == PH_IDLE) begin
                    n_step = step_inc;
                end
            end else begin
                n_count = count_inc;
            end
        end
    end

    // result from the updated state
    always_comb begin
        coil     = i_cfg.coil_order[{n_step, 1'b0} +: 2];
        coil_bit = ({1'b0, coil} < 3'(NUM_COILS)) ? (4'd1 << coil) : 4'd0;

        o_result.high_relay_n = 4'hF;
        o_result.low_relay_n  = 4'hF;
        if (n_phase inside {PH_L_SET1, PH_L_PULSE, PH_L_SET2}) begin
            o_result.low_relay_n = 4'hF & ~coil_bit;
        end
        if (n_phase inside {PH_H_SET1, PH_H_PULSE, PH_H_SET2}) begin
            o_result.high_relay_n = 4'hF & ~coil_bit;
        end
        o_result.high_relay_n = o_result.high_relay_n | ~COIL_MASK;
        o_result.low_relay_n  = o_result.low_relay_n | ~COIL_MASK;
        o_result.pulse_on     = (n_phase == PH_L_PULSE) || (n_phase == PH_H_PULSE);
        o_result.busy_res     = (n_phase != PH_IDLE);
        o_result.step         = n_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_count   <= '0;
            r_step    <= 2'd0;
            r_latched <= 1'b0;
            r_since   <= SP_MAX;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_step    <= n_step;
            r_latched <= n_latched;
            r_since   <= n_since;
        end
    end

    a_idle_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_count == '0))
        else $error("phase counter nonzero while idle");

    a_low_clears_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_IDLE && !i_button) |=> !r_latched)
        else $error("low button while idle did not clear the latch");

    a_step_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_step) |-> (r_phase == PH_IDLE))
        else $error("order index moved while a sequence still runs");

    a_hold_without_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> ($stable(r_phase) && $stable(r_count) && $stable(r_since)))
        else $error("state moved without a tick");

endmodule

>>> rtl/cpps_out_skid.sv
`timescale 1ns / 1ps
// cpps_out_skid: output register plus one skid entry, so a new tick is taken
// while a result waits. Depends on cpps_pkg.

module cpps_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cpps_pkg::t_result i_result,
    input  logic              i_out_stall,
    output logic              o_full,
    output logic              o_out_valid,
    output cpps_pkg::t_result o_result
);
    import cpps_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_stalled_push_skids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !r_skid_valid && r_out_valid && !pop) |=> r_skid_valid)
        else $error("transaction lost behind a stalled output");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && pop) |=> (!r_skid_valid && r_out_valid))
        else $error("skid entry not moved to the output register");

endmodule
